// ----- hdl/tps_pkg.sv -----
// Shared types, codes and helpers for the traffic phase scheduler.
package tps_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned LAMP_W  = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0] DEFAULT_DURATION_RESET = 32'd10000;

   // Phase codes.
   localparam logic [PHASE_W-1:0] PHASE_NONE      = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_ROW_FIRST = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_ROW_LAST  = 3'd4;
   localparam logic [PHASE_W-1:0] PHASE_EMERGENCY = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_DURATION  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMERGENCY_ENABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMMEDIATE_PREEMPT = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [PHASE_W-1:0] emergency_row_request;
      logic               extend_valid;
      logic [TIME_W-1:0]  extend_ms;
   } req_word_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [LAMP_W-1:0]  row_lamps;
      logic               allow_extension;
      logic               emergency_active;
   } rsp_word_type;

   function automatic logic is_row(input logic [PHASE_W-1:0] code);
      return (code >= PHASE_ROW_FIRST) && (code <= PHASE_ROW_LAST);
   endfunction

   // One-hot lamp for rows 1..4; bit 0 is row 1.
   function automatic logic [LAMP_W-1:0] row_onehot(input logic [PHASE_W-1:0] row);
      logic [1:0] sel;
      sel = 2'(row - PHASE_ROW_FIRST);
      return LAMP_W'(1) << sel;
   endfunction

endpackage

// ----- hdl/tps_req_if.sv -----
// Valid/ready channel that carries one input word.
interface tps_req_if
   import tps_pkg::*;
();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/tps_rsp_if.sv -----
// Valid/ready channel that carries one result word.
interface tps_rsp_if
   import tps_pkg::*;
();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/traffic_phase_scheduler_preempt.sv -----
// Traffic phase scheduler with emergency preemption, top level.
//
// Usage: every tick the host sends one word on the req channel holding the
// current millisecond time, an optional emergency row request and an
// optional phase-duration override. For each word the block returns exactly
// one word on the rsp channel with the shown phase, the one-hot row lamps,
// the extension-allowed flag and the emergency-active flag.
// Words are accepted when valid and ready are both high at a clock edge.
// An accepted word lands in an input register; the scheduler step runs
// from that register when the result register is free or being emptied
// and writes the result register. One word per cycle is sustained while
// rsp is not stalled: the step is a handful of 32-bit subtract/compare paths.
// If the receiver stalls, the result register holds and the input register
// still takes one more word; only then does req.ready drop.
// The csr port writes registers at any edge with csr_we high; it is meant
// to be used only while no word is in flight. Writing default_duration also
// reloads the current phase duration.
// Synchronous reset restores all but the payload registers to their reset
// values as documented: next phase 1, phase shown 0, lamps dark, extension allowed.
module traffic_phase_scheduler_preempt
   import tps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tps_req_if.sink               req,
   tps_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [TIME_W-1:0] default_duration_ff;
   logic              emergency_enable_ff;
   logic              immediate_preempt_ff;

   // Input stage.
   logic         in_valid_ff;
   req_word_type in_word_ff;

   // Output stage.
   logic         out_valid_ff;
   rsp_word_type out_word_ff;

   // Scheduler state and its next values.
   logic [TIME_W-1:0]  phase_start_ff,     phase_start_in;
   logic [TIME_W-1:0]  emerg_start_ff,     emerg_start_in;
   logic [TIME_W-1:0]  phase_duration_ff,  phase_duration_in;
   logic [PHASE_W-1:0] next_phase_ff,      next_phase_in;
   logic [PHASE_W-1:0] held_phase_ff,      held_phase_in;
   logic [PHASE_W-1:0] emerg_row_ff,       emerg_row_in;
   logic               in_emergency_ff,    in_emergency_in;
   logic               extended_ff,        extended_in;
   logic [TIME_W-1:0]  held_elapsed_ff,    held_elapsed_in;
   logic               resume_hold_ff,     resume_hold_in;
   logic [PHASE_W-1:0] shown_phase_ff,     shown_phase_in;
   logic [LAMP_W-1:0]  lamp_ff,            lamp_in;
   logic               ext_allowed_ff,     ext_allowed_in;

   logic advance;
   logic in_load;

   // A step runs when a word is staged and the result register is free or
   // being emptied this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign in_load   = req.valid && req.ready;

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_word_ff;

   // One scheduler step, in the same order of decisions as the algorithm:
   // duration override, timeout check, extension bookkeeping, emergency
   // request, return from emergency, then the phase change itself.
   always_comb begin
      logic [PHASE_W-1:0] req_row;
      logic               change;

      phase_start_in    = phase_start_ff;
      emerg_start_in    = emerg_start_ff;
      phase_duration_in = phase_duration_ff;
      next_phase_in     = next_phase_ff;
      held_phase_in     = held_phase_ff;
      emerg_row_in      = emerg_row_ff;
      in_emergency_in   = in_emergency_ff;
      extended_in       = extended_ff;
      held_elapsed_in   = held_elapsed_ff;
      resume_hold_in    = resume_hold_ff;
      shown_phase_in    = shown_phase_ff;
      lamp_in           = lamp_ff;
      ext_allowed_in    = ext_allowed_ff;

      if (in_word_ff.extend_valid) begin
         phase_duration_in = in_word_ff.extend_ms;
      end

      // Elapsed time wraps modulo 2^32, so plain subtraction is correct.
      if (!in_emergency_ff) begin
         change = (in_word_ff.now_ms - phase_start_ff) > phase_duration_in;
      end else begin
         change = (in_word_ff.now_ms - emerg_start_ff) > phase_duration_in;
      end

      // The first override that differs from the default closes the window.
      if ((phase_duration_in != default_duration_ff) && !extended_ff) begin
         extended_in    = 1'b1;
         ext_allowed_in = 1'b0;
      end

      req_row = emergency_enable_ff ? in_word_ff.emergency_row_request : PHASE_NONE;
      if (is_row(req_row)) begin
         if (!immediate_preempt_ff) begin
            held_phase_in = next_phase_ff;
         end else begin
            // Preempt now and remember how far the interrupted phase had run.
            held_phase_in   = shown_phase_ff;
            held_elapsed_in = in_word_ff.now_ms - phase_start_ff;
            change          = 1'b1;
            emerg_start_in  = in_word_ff.now_ms;
         end
         next_phase_in  = PHASE_EMERGENCY;
         emerg_row_in   = req_row;
         shown_phase_in = req_row;
      end

      // Leaving the emergency phase resumes the held phase.
      if (in_emergency_ff && change) begin
         in_emergency_in = 1'b0;
         next_phase_in   = held_phase_in;
         held_phase_in   = PHASE_NONE;
         if (immediate_preempt_ff) begin
            phase_start_in = in_word_ff.now_ms - held_elapsed_in;
            resume_hold_in = 1'b1;
         end
      end

      if (change) begin
         ext_allowed_in    = 1'b1;
         extended_in       = 1'b0;
         phase_duration_in = default_duration_ff;
         // A resumed phase keeps its back-dated start time for one change.
         if (resume_hold_in && !in_emergency_in) begin
            resume_hold_in = 1'b0;
         end else begin
            phase_start_in = in_word_ff.now_ms;
         end

         if (is_row(next_phase_in)) begin
            shown_phase_in = next_phase_in;
            lamp_in        = row_onehot(next_phase_in);
            next_phase_in  = (next_phase_in == PHASE_ROW_LAST) ? PHASE_ROW_FIRST
                                                               : next_phase_in + 3'd1;
         end else if (next_phase_in == PHASE_EMERGENCY) begin
            shown_phase_in = PHASE_EMERGENCY;
            emerg_start_in = in_word_ff.now_ms;
            if (is_row(emerg_row_in)) begin
               lamp_in = row_onehot(emerg_row_in);
            end
            in_emergency_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_duration_ff  <= DEFAULT_DURATION_RESET;
         emergency_enable_ff  <= 1'b1;
         immediate_preempt_ff <= 1'b0;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         phase_start_ff       <= '0;
         emerg_start_ff       <= '0;
         phase_duration_ff    <= DEFAULT_DURATION_RESET;
         next_phase_ff        <= PHASE_ROW_FIRST;
         held_phase_ff        <= PHASE_NONE;
         emerg_row_ff         <= PHASE_NONE;
         in_emergency_ff      <= 1'b0;
         extended_ff          <= 1'b0;
         held_elapsed_ff      <= '0;
         resume_hold_ff       <= 1'b0;
         shown_phase_ff       <= PHASE_NONE;
         lamp_ff              <= '0;
         ext_allowed_ff       <= 1'b1;
      end else begin
         if (in_load) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end

         if (advance) begin
            phase_start_ff    <= phase_start_in;
            emerg_start_ff    <= emerg_start_in;
            phase_duration_ff <= phase_duration_in;
            next_phase_ff     <= next_phase_in;
            held_phase_ff     <= held_phase_in;
            emerg_row_ff      <= emerg_row_in;
            in_emergency_ff   <= in_emergency_in;
            extended_ff       <= extended_in;
            held_elapsed_ff   <= held_elapsed_in;
            resume_hold_ff    <= resume_hold_in;
            shown_phase_ff    <= shown_phase_in;
            lamp_ff           <= lamp_in;
            ext_allowed_ff    <= ext_allowed_in;
         end

         // Writes must arrive only while idle so they never race a step; the block does not enforce it.
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEFAULT_DURATION: begin
                  default_duration_ff <= csr_wdata[TIME_W-1:0];
                  phase_duration_ff   <= csr_wdata[TIME_W-1:0];
               end
               CSR_EMERGENCY_ENABLE: begin
                  emergency_enable_ff <= csr_wdata[0];
               end
               CSR_IMMEDIATE_PREEMPT: begin
                  immediate_preempt_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_word_ff <= req.payload;
      end
      if (advance) begin
         out_word_ff.phase            <= shown_phase_in;
         out_word_ff.row_lamps        <= lamp_in;
         out_word_ff.allow_extension  <= ext_allowed_in;
         out_word_ff.emergency_active <= in_emergency_in;
      end
   end

endmodule
